@@ design/tsidb_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick-scheduled input delay buffer: shared package
// Field widths, command and kind codes, register indexes and the packed
// records passed between the front end, the slot wheel and the top level.
// ----------------------------------------------------------------------------
package tsidb_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int KIND_W    = 2;
	localparam int DELAY_W   = 8;
	localparam int TICK_W    = 32;
	localparam int AXIS_W    = 16;
	localparam int PRESENT_W = 7;
	localparam int FLAG_W    = 5;
	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 1;

	// Largest delay that the clamp can produce
	localparam int DELAY_MAX = (2 ** CFG_W) - 1;

	// Serial-number comparison window
	localparam logic [TICK_W-1:0] HALF_RANGE = 32'h8000_0000;

	// Register reset values
	localparam logic [CFG_W-1:0] MIN_DELAY_RST = 4'd2;
	localparam logic [CFG_W-1:0] MAX_DELAY_RST = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH     = 2'd0,
		CMD_PUSH_SEQ = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MOVE    = 2'd0,
		KIND_CHORES  = 2'd1,
		KIND_EQUIP   = 2'd2,
		KIND_UNEQUIP = 2'd3
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MIN_DELAY = 1'd0,
		REG_MAX_DELAY = 1'd1
	} reg_idx_t;

	// Merged content of one slot
	typedef struct packed {
		logic                        carries_move;
		logic                        carries_chores;
		logic signed [AXIS_W-1:0]    mx;
		logic signed [AXIS_W-1:0]    my;
		logic        [PRESENT_W-1:0] present;
		logic        [FLAG_W-1:0]    flags;
	} payload_t;

	// One stored slot: target tick and payload
	typedef struct packed {
		logic [TICK_W-1:0] tag;
		payload_t          pl;
	} entry_t;

	// Decoded command held in the first pipeline stage
	typedef struct packed {
		cmd_t                        op;
		logic                        ok;
		logic        [TICK_W-1:0]    target;
		logic signed [AXIS_W-1:0]    mx;
		logic signed [AXIS_W-1:0]    my;
		logic        [PRESENT_W-1:0] present;
		logic        [FLAG_W-1:0]    flags;
	} s1_cmd_t;

	// One result item
	typedef struct packed {
		logic                        accepted;
		logic                        due;
		logic                        carries_move;
		logic                        carries_chores;
		logic signed [AXIS_W-1:0]    mx;
		logic signed [AXIS_W-1:0]    my;
		logic        [PRESENT_W-1:0] present;
		logic        [FLAG_W-1:0]    flags;
	} result_t;

endpackage

@@ design/tsidb_front.sv @@
// ----------------------------------------------------------------------------
// Tick-scheduled input delay buffer: command front end
// Keeps the local tick and the sequence state, clamps the delay, works out
// the target tick and slot index, and registers the decoded command.
// ----------------------------------------------------------------------------
module tsidb_front #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 adv,
	input  logic [tsidb_pkg::CMD_W-1:0]          command,
	input  logic [tsidb_pkg::KIND_W-1:0]         op_kind,
	input  logic [tsidb_pkg::DELAY_W-1:0]        delay,
	input  logic [tsidb_pkg::TICK_W-1:0]         sequence_req,
	input  logic signed [tsidb_pkg::AXIS_W-1:0]  move_x,
	input  logic signed [tsidb_pkg::AXIS_W-1:0]  move_y,
	input  logic [tsidb_pkg::PRESENT_W-1:0]      present_mask,
	input  logic [tsidb_pkg::FLAG_W-1:0]         flag_values,
	input  logic [tsidb_pkg::CFG_W-1:0]          min_delay,
	input  logic [tsidb_pkg::CFG_W-1:0]          max_delay,
	output logic [$clog2(QUEUE_DEPTH)-1:0]       rd_addr,
	output logic                                 valid_s1,
	output tsidb_pkg::s1_cmd_t                   cmd_s1,
	output logic [$clog2(QUEUE_DEPTH)-1:0]       idx_s1
);
	import tsidb_pkg::*;

	localparam int IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int SUM_W     = $clog2(QUEUE_DEPTH + DELAY_MAX);
	localparam int RED_STEPS = (QUEUE_DEPTH + DELAY_MAX - 1) / QUEUE_DEPTH;

	// Brings a small sum back into the range of slot indexes
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = v;
		for (int s = 0; s < RED_STEPS; s++) begin
			if (r >= SUM_W'(QUEUE_DEPTH)) begin
				r = r - SUM_W'(QUEUE_DEPTH);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	logic [TICK_W-1:0] local_tick_q;
	logic [IDX_W-1:0]  tick_idx_q;
	logic [TICK_W-1:0] last_seq_q;
	logic              seq_known_q;

	cmd_t              op;
	logic [DELAY_W-1:0] d_wide;
	logic [CFG_W-1:0]  clamp_d;
	logic              kind_ok;
	logic [TICK_W-1:0] seq_gap;
	logic              seq_ok;
	logic              push_ok;
	logic [TICK_W:0]   push_sum;
	logic [TICK_W-1:0] push_target;
	logic [SUM_W-1:0]  push_v;
	logic [IDX_W-1:0]  push_idx;
	logic [TICK_W-1:0] tick_target;
	logic [IDX_W-1:0]  tick_idx_nxt;

	assign op = cmd_t'(command);

	// Delay clamp: raise to the minimum first, then cap at the maximum
	always_comb begin
		d_wide = (op == CMD_PUSH_SEQ) ? delay : DELAY_W'(min_delay);
		if (d_wide < DELAY_W'(min_delay)) begin
			d_wide = DELAY_W'(min_delay);
		end
		if (d_wide > DELAY_W'(max_delay)) begin
			d_wide = DELAY_W'(max_delay);
		end
		clamp_d = d_wide[CFG_W-1:0];
	end

	// Kind filter and serial-number check
	assign kind_ok = (kind_t'(op_kind) == KIND_MOVE) || (kind_t'(op_kind) == KIND_CHORES);
	assign seq_gap = sequence_req - last_seq_q;
	assign seq_ok  = !seq_known_q || ((seq_gap != '0) && (seq_gap < HALF_RANGE));
	assign push_ok = kind_ok && ((op == CMD_PUSH) || ((op == CMD_PUSH_SEQ) && seq_ok));

	// Push target and its slot; a target that wraps past zero is small
	assign push_sum    = {1'b0, local_tick_q} + (TICK_W + 1)'(clamp_d);
	assign push_target = push_sum[TICK_W-1:0];
	assign push_v      = push_sum[TICK_W] ? push_target[SUM_W-1:0]
	                                      : SUM_W'(tick_idx_q) + SUM_W'(clamp_d);
	assign push_idx    = wrap_idx(push_v);

	// Next tick and its slot, kept incrementally
	assign tick_target  = local_tick_q + 1'b1;
	assign tick_idx_nxt = ((local_tick_q == '1) || (tick_idx_q == IDX_W'(QUEUE_DEPTH - 1)))
	                      ? '0 : tick_idx_q + 1'b1;

	assign rd_addr = (op == CMD_TICK) ? tick_idx_nxt : push_idx;

	// Tick and sequence state advance in the order of accepted transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_tick_q <= '0;
			tick_idx_q   <= '0;
			last_seq_q   <= '0;
			seq_known_q  <= 1'b0;
		end else if (accept) begin
			case (op)
				CMD_TICK: begin
					local_tick_q <= tick_target;
					tick_idx_q   <= tick_idx_nxt;
				end
				CMD_PUSH_SEQ: begin
					if (push_ok) begin
						last_seq_q  <= sequence_req;
						seq_known_q <= 1'b1;
					end
				end
				CMD_CLEAR: begin
					last_seq_q  <= '0;
					seq_known_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage-one occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-one command register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op      <= op;
			cmd_s1.ok      <= push_ok;
			cmd_s1.target  <= (op == CMD_TICK) ? tick_target : push_target;
			cmd_s1.mx      <= move_x;
			cmd_s1.my      <= move_y;
			cmd_s1.present <= present_mask;
			cmd_s1.flags   <= flag_values;
			idx_s1         <= rd_addr;
		end
	end

	// The incremental slot index never leaves the ring.
	a_tick_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tick_idx_q) < QUEUE_DEPTH)
		else $error("tick slot index out of range");

	// A clear forgets the sequence.
	a_clear_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == CMD_CLEAR) |=> !seq_known_q)
		else $error("sequence still known after clear");

endmodule

@@ design/tsidb_wheel.sv @@
// ----------------------------------------------------------------------------
// Tick-scheduled input delay buffer: slot wheel
// Holds the slot memory and the slot valid bits, merges pushes into their
// slot and takes out the due slot on a tick.
// ----------------------------------------------------------------------------
module tsidb_wheel #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	input  logic                           adv,
	input  tsidb_pkg::s1_cmd_t             cmd_s1,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] idx_s1,
	output tsidb_pkg::result_t             result
);
	import tsidb_pkg::*;

	entry_t                 slot_mem_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] slot_valid_q;
	entry_t                 rd_entry_q;
	entry_t                 fwd_entry_q;
	logic                   fwd_hit_q;

	entry_t   entry;
	logic     hit;
	payload_t base;
	payload_t merged;
	entry_t   wr_entry;
	logic     wr_en;

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[idx_s1] <= wr_entry;
		end
	end

	// The read is taken with the transfer; a write to the same slot at that
	// edge is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q  <= slot_mem_q[rd_addr];
			fwd_hit_q   <= wr_en && (idx_s1 == rd_addr);
			fwd_entry_q <= wr_entry;
		end
	end

	assign entry = fwd_hit_q ? fwd_entry_q : rd_entry_q;
	assign hit   = slot_valid_q[idx_s1] && (entry.tag == cmd_s1.target);

	// Merge of the present fields into the slot, which starts empty unless it is valid with the same target tick
	always_comb begin
		base   = hit ? entry.pl : '0;
		merged = base;
		if (cmd_s1.present[1:0] != '0) begin
			if (cmd_s1.present[0]) begin
				merged.mx = cmd_s1.mx;
			end
			if (cmd_s1.present[1]) begin
				merged.my = cmd_s1.my;
			end
			merged.carries_move = 1'b1;
		end
		for (int i = 0; i < FLAG_W; i++) begin
			if (cmd_s1.present[i + 2]) begin
				merged.flags[i] = cmd_s1.flags[i];
			end
		end
		if (cmd_s1.present[PRESENT_W-1:2] != '0) begin
			merged.carries_chores = 1'b1;
		end
		merged.present = base.present | cmd_s1.present;
	end

	assign wr_entry = '{tag: cmd_s1.target, pl: merged};

	// Result of the command in stage one
	always_comb begin
		wr_en  = 1'b0;
		result = '0;
		case (cmd_s1.op) inside
			CMD_PUSH, CMD_PUSH_SEQ: begin
				wr_en           = adv && cmd_s1.ok;
				result.accepted = cmd_s1.ok;
			end
			CMD_TICK: begin
				if (hit) begin
					result.due            = 1'b1;
					result.carries_move   = entry.pl.carries_move;
					result.carries_chores = entry.pl.carries_chores;
					result.mx             = entry.pl.mx;
					result.my             = entry.pl.my;
					result.present        = entry.pl.present;
					result.flags          = entry.pl.flags;
				end
			end
			default: begin
			end
		endcase
	end

	// Slot valid bits: set on claim, freed on emission, wiped on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (adv) begin
			case (cmd_s1.op)
				CMD_CLEAR: begin
					slot_valid_q <= '0;
				end
				CMD_TICK: begin
					if (hit) begin
						slot_valid_q[idx_s1] <= 1'b0;
					end
				end
				default: begin
					if (cmd_s1.ok) begin
						slot_valid_q[idx_s1] <= 1'b1;
					end
				end
			endcase
		end
	end

	// A clear leaves no slot occupied.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1.op == CMD_CLEAR) |=> (slot_valid_q == '0))
		else $error("slot still valid after clear");

	// An accepted push leaves its slot occupied.
	a_push_claims: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> slot_valid_q[$past(idx_s1)])
		else $error("pushed slot not valid");

	// An emitted slot is freed.
	a_due_frees: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1.op == CMD_TICK) && hit |=> !slot_valid_q[$past(idx_s1)])
		else $error("due slot not freed");

endmodule

@@ design/tick_scheduled_input_delay_buffer_core.sv @@
// ----------------------------------------------------------------------------
// Tick-scheduled input delay buffer
// Timing wheel of QUEUE_DEPTH slots that delays pushed player operations
// by a clamped number of ticks and emits each slot when its tick comes.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the input channel (in_valid / in_stall); each command
//   gives exactly one result on the output channel (out_valid / out_stall).
//   A push reports whether it was scheduled; a tick reports the slot that
//   falls due, if any; a clear reports an empty result.
//   One command is taken every cycle while in_stall is low: the slot store
//   is a memory with one write and one registered read port, and a write
//   in the merge stage is forwarded to a read of the same slot issued at
//   that edge. The result waits in an output register; while the receiver
//   stalls and that register is full, the command in the merge stage holds
//   and in_stall rises, so no result is lost.
//   Reset clears the local tick, the sequence state and all slot valid bits
//   at once and loads min_delay 2 and max_delay 8; no clearing pass is
//   needed. Registers are to be written through wr_en / wr_index / wr_data
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tick_scheduled_input_delay_buffer_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration
	input  logic                                 wr_en,
	input  logic [tsidb_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [tsidb_pkg::CFG_W-1:0]          wr_data,
	// Command channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [tsidb_pkg::CMD_W-1:0]          command,
	input  logic [tsidb_pkg::KIND_W-1:0]         op_kind,
	input  logic [tsidb_pkg::DELAY_W-1:0]        delay,
	input  logic [tsidb_pkg::TICK_W-1:0]         sequence_req,
	input  logic signed [tsidb_pkg::AXIS_W-1:0]  move_x,
	input  logic signed [tsidb_pkg::AXIS_W-1:0]  move_y,
	input  logic [tsidb_pkg::PRESENT_W-1:0]      present_mask,
	input  logic [tsidb_pkg::FLAG_W-1:0]         flag_values,
	// Result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	output logic                                 due,
	output logic                                 carries_move,
	output logic                                 carries_chores,
	output logic signed [tsidb_pkg::AXIS_W-1:0]  out_move_x,
	output logic signed [tsidb_pkg::AXIS_W-1:0]  out_move_y,
	output logic [tsidb_pkg::PRESENT_W-1:0]      out_present,
	output logic [tsidb_pkg::FLAG_W-1:0]         out_flags
);
	import tsidb_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic [CFG_W-1:0] min_delay_q;
	logic [CFG_W-1:0] max_delay_q;

	logic             accept;
	logic             adv;
	logic             valid_s1;
	s1_cmd_t          cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] rd_addr;
	result_t          result;
	result_t          out_q;
	logic             out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
			max_delay_q <= MAX_DELAY_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_MIN_DELAY: min_delay_q <= wr_data;
				REG_MAX_DELAY: max_delay_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the merge stage moves on when the output register is free
	// or is being emptied
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	tsidb_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.adv          (adv),
		.command      (command),
		.op_kind      (op_kind),
		.delay        (delay),
		.sequence_req (sequence_req),
		.move_x       (move_x),
		.move_y       (move_y),
		.present_mask (present_mask),
		.flag_values  (flag_values),
		.min_delay    (min_delay_q),
		.max_delay    (max_delay_q),
		.rd_addr      (rd_addr),
		.valid_s1     (valid_s1),
		.cmd_s1       (cmd_s1),
		.idx_s1       (idx_s1)
	);

	tsidb_wheel #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_wheel (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.adv     (adv),
		.cmd_s1  (cmd_s1),
		.idx_s1  (idx_s1),
		.result  (result)
	);

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = out_q.accepted;
	assign due            = out_q.due;
	assign carries_move   = out_q.carries_move;
	assign carries_chores = out_q.carries_chores;
	assign out_move_x     = out_q.mx;
	assign out_move_y     = out_q.my;
	assign out_present    = out_q.present;
	assign out_flags      = out_q.flags;

	// The merge stage only moves when its result has a place to go.
	a_adv_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> valid_s1 && !(out_valid_q && out_stall))
		else $error("merge stage advanced into a full output register");

endmodule
